// ----- hdl/upq_pkg.sv -----
// ----------------------------------------------------------------------------
// upq_pkg: shared types and constants for the unsorted priority queue
// Field widths, stream packing positions, operation and status codes.
// ----------------------------------------------------------------------------
package upq_pkg;

   localparam int MODE_W   = 2;
   localparam int KEY_W    = 16;
   localparam int PRIO_W   = 16;
   localparam int STATUS_W = 3;
   localparam int OCC_W    = 7;

   // request tdata: mode, key, priority_req (lowest bit up), padded to bytes
   localparam int REQ_MODE_LSB = 0;
   localparam int REQ_KEY_LSB  = REQ_MODE_LSB + MODE_W;
   localparam int REQ_PRIO_LSB = REQ_KEY_LSB + KEY_W;
   localparam int REQ_USED_W   = REQ_PRIO_LSB + PRIO_W;
   localparam int REQ_W        = ((REQ_USED_W + 7) / 8) * 8;

   // response tdata: status, served_key, front_valid, front_key,
   // front_priority, occupancy (lowest bit up), padded to bytes
   localparam int RSP_STATUS_LSB = 0;
   localparam int RSP_SERVED_LSB = RSP_STATUS_LSB + STATUS_W;
   localparam int RSP_FVALID_LSB = RSP_SERVED_LSB + KEY_W;
   localparam int RSP_FKEY_LSB   = RSP_FVALID_LSB + 1;
   localparam int RSP_FPRIO_LSB  = RSP_FKEY_LSB + KEY_W;
   localparam int RSP_OCC_LSB    = RSP_FPRIO_LSB + PRIO_W;
   localparam int RSP_USED_W     = RSP_OCC_LSB + OCC_W;
   localparam int RSP_W          = ((RSP_USED_W + 7) / 8) * 8;

   typedef enum logic [MODE_W-1:0] {
      MODE_INSERT  = 2'd0,
      MODE_SERVE   = 2'd1,
      MODE_UPGRADE = 2'd2,
      MODE_CLEAR   = 2'd3
   } mode_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK        = 3'd0,
      ST_EMPTY     = 3'd1,
      ST_ABSENT    = 3'd2,
      ST_NOT_LOWER = 3'd3,
      ST_FULL      = 3'd4
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SEARCH,
      S_APPLY,
      S_FRONT,
      S_RESULT
   } state_type;

   typedef struct packed {
      logic [KEY_W-1:0]  key;
      logic [PRIO_W-1:0] prio;
   } entry_type;

   typedef struct packed {
      logic take_nbr;
      logic take_new;
   } cell_ctrl_type;

endpackage

// ----- hdl/upq_cell.sv -----
// ----------------------------------------------------------------------------
// upq_cell: one storage cell of the queue ring
// Holds one entry; loads either its neighbor's entry or a new entry.
// ----------------------------------------------------------------------------
module upq_cell import upq_pkg::*; (
   input  logic          clock,
   input  cell_ctrl_type ctrl,
   input  entry_type     nbr,
   input  entry_type     new_entry,
   output entry_type     q
);

   entry_type entry_ff;

   always_ff @(posedge clock) begin
      if (ctrl.take_new) begin
         entry_ff <= new_entry;
      end else if (ctrl.take_nbr) begin
         entry_ff <= nbr;
      end
   end

   assign q = entry_ff;

endmodule

// ----- hdl/upq_scan.sv -----
// ----------------------------------------------------------------------------
// upq_scan: running minimum over the entries passing the ring head
// Tracks the most urgent entry overall and the most urgent with a given key.
// ----------------------------------------------------------------------------
module upq_scan import upq_pkg::*; #(
   parameter int IDX_W = 6
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              clear,
   input  logic              sample,
   input  entry_type         head,
   input  logic [IDX_W-1:0]  pos,
   input  logic [KEY_W-1:0]  match_key,
   output logic              any_found,
   output entry_type         any_entry,
   output logic [IDX_W-1:0]  any_idx,
   output logic              key_found,
   output logic [PRIO_W-1:0] key_prio,
   output logic [IDX_W-1:0]  key_idx
);

   logic              any_found_ff;
   entry_type         any_entry_ff;
   logic [IDX_W-1:0]  any_idx_ff;
   logic              key_found_ff;
   logic [PRIO_W-1:0] key_prio_ff;
   logic [IDX_W-1:0]  key_idx_ff;
   logic              take_any;
   logic              take_key;

   // strict compare keeps the earliest entry on ties
   assign take_any = sample && (!any_found_ff || (head.prio < any_entry_ff.prio));
   assign take_key = sample && (head.key == match_key) &&
                     (!key_found_ff || (head.prio < key_prio_ff));

   always_ff @(posedge clock) begin
      if (reset || clear) begin
         any_found_ff <= 1'b0;
         key_found_ff <= 1'b0;
      end else begin
         if (take_any) begin
            any_found_ff <= 1'b1;
         end
         if (take_key) begin
            key_found_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take_any) begin
         any_entry_ff <= head;
         any_idx_ff   <= pos;
      end
      if (take_key) begin
         key_prio_ff <= head.prio;
         key_idx_ff  <= pos;
      end
   end

   assign any_found = any_found_ff;
   assign any_entry = any_entry_ff;
   assign any_idx   = any_idx_ff;
   assign key_found = key_found_ff;
   assign key_prio  = key_prio_ff;
   assign key_idx   = key_idx_ff;

endmodule

// ----- hdl/unsorted_priority_queue.sv -----
// ----------------------------------------------------------------------------
// unsorted_priority_queue: arrival-ordered priority queue with decrease-key
// Entries live in a ring of cells; a single scan unit watches the ring head.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on the req_ stream (insert, serve, upgrade, clear); each
//   request yields exactly one transfer on the rsp_ stream with the status,
//   the served key, the most urgent entry left and the occupancy.
//   Search: for serve and upgrade the cell ring rotates one position per cycle,
//   a full turn, while the head entry is compared against the running best;
//   insert and clear skip this search. Then the update is applied (cells at
//   or above the removed slot take their neighbor, the new entry lands at the
//   tail), then a second ring rotation finds the new front.
//   One request is in work at a time; the next is taken only after the
//   response is registered, so the block cannot accept a new request before
//   it is through with the last.
//   Reset empties the queue at once (occupancy zero); cell contents are left
//   as they are and never read before written.
//   A stalled response sits in the output register; the block takes and works
//   on the next request meanwhile and holds its own result until the
//   register frees.
// ----------------------------------------------------------------------------
module unsorted_priority_queue import upq_pkg::*; #(
   parameter int DEPTH = 64
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   input  logic [REQ_W-1:0] req_tdata,  // mode, key, priority_req
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic [RSP_W-1:0] rsp_tdata   // status, served_key, front_valid,
                                        // front_key, front_priority, occupancy
);

   localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   state_type         state_ff, state_in;
   mode_type          mode_ff;
   logic [KEY_W-1:0]  key_ff;
   logic [PRIO_W-1:0] prio_ff;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [IDX_W-1:0]  pos_ff, pos_in;
   status_type        status_ff, status_in;
   logic [KEY_W-1:0]  served_ff, served_in;
   logic              rsp_valid_ff;
   logic [RSP_W-1:0]  rsp_data_ff, rsp_data_in;

   logic              req_xfer;
   logic              pos_last;
   logic              rotate;
   logic              scan_clear;
   logic              scan_sample;
   logic              app_en;
   logic              cmp_en;
   logic [IDX_W-1:0]  wr_idx;
   logic [IDX_W-1:0]  rm_idx;
   logic              rsp_free;

   logic              any_found;
   entry_type         any_entry;
   logic [IDX_W-1:0]  any_idx;
   logic              key_found;
   logic [PRIO_W-1:0] key_prio;
   logic [IDX_W-1:0]  key_idx;

   entry_type         cell_q [DEPTH];
   cell_ctrl_type     cell_ctrl [DEPTH];
   entry_type         new_entry;
   logic [KEY_W-1:0]  front_key;
   logic [PRIO_W-1:0] front_prio;

   assign req_tready = (state_ff == S_IDLE);
   assign req_xfer   = req_tvalid && req_tready;
   assign pos_last   = (pos_ff == IDX_W'(DEPTH - 1));
   assign rsp_free   = !rsp_valid_ff || rsp_tready;

   // ---- state machine
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_xfer) begin
               if ((mode_type'(req_tdata[REQ_MODE_LSB +: MODE_W]) == MODE_SERVE) ||
                   (mode_type'(req_tdata[REQ_MODE_LSB +: MODE_W]) == MODE_UPGRADE)) begin
                  state_in = S_SEARCH;
               end else begin
                  state_in = S_APPLY;
               end
            end
         end
         S_SEARCH: begin
            if (pos_last) begin
               state_in = S_APPLY;
            end
         end
         S_APPLY: state_in = S_FRONT;
         S_FRONT: begin
            if (pos_last) begin
               state_in = S_RESULT;
            end
         end
         S_RESULT: begin
            if (rsp_free) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      rotate      = (state_ff == S_SEARCH) || (state_ff == S_FRONT);
      scan_clear  = req_xfer || (state_ff == S_APPLY);
      scan_sample = rotate && ({{(CNT_W > IDX_W ? CNT_W - IDX_W : 0){1'b0}}, pos_ff} < CNT_W'(count_ff));
      if (rotate && !pos_last) begin
         pos_in = pos_ff + IDX_W'(1);
      end else begin
         pos_in = '0;
      end
   end

   // ---- update decision, used in the apply cycle
   always_comb begin
      status_in = ST_OK;
      served_in = '0;
      count_in  = count_ff;
      app_en    = 1'b0;
      cmp_en    = 1'b0;
      wr_idx    = IDX_W'(count_ff);
      rm_idx    = any_idx;
      unique case (mode_ff)
         MODE_INSERT: begin
            if (count_ff == CNT_W'(DEPTH)) begin
               status_in = ST_FULL;
            end else begin
               app_en   = 1'b1;
               count_in = count_ff + CNT_W'(1);
            end
         end
         MODE_SERVE: begin
            if (count_ff == '0) begin
               status_in = ST_EMPTY;
            end else begin
               served_in = any_entry.key;
               cmp_en    = 1'b1;
               count_in  = count_ff - CNT_W'(1);
            end
         end
         MODE_UPGRADE: begin
            rm_idx = key_idx;
            wr_idx = IDX_W'(count_ff - CNT_W'(1));
            if (!key_found) begin
               status_in = ST_ABSENT;
            end else if (key_prio <= prio_ff) begin
               status_in = ST_NOT_LOWER;
            end else begin
               cmp_en = 1'b1;
               app_en = 1'b1;
            end
         end
         MODE_CLEAR: count_in = '0;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         pos_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         pos_ff   <= pos_in;
         if (state_ff == S_APPLY) begin
            count_ff <= count_in;
         end
         if (state_ff == S_RESULT && rsp_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign front_key  = any_found ? any_entry.key  : '0;
   assign front_prio = any_found ? any_entry.prio : '0;

   always_comb begin
      rsp_data_in = '0;
      rsp_data_in[RSP_STATUS_LSB +: STATUS_W] = status_ff;
      rsp_data_in[RSP_SERVED_LSB +: KEY_W]    = served_ff;
      rsp_data_in[RSP_FVALID_LSB]             = any_found;
      rsp_data_in[RSP_FKEY_LSB +: KEY_W]      = front_key;
      rsp_data_in[RSP_FPRIO_LSB +: PRIO_W]    = front_prio;
      rsp_data_in[RSP_OCC_LSB +: OCC_W]       = OCC_W'(count_ff);
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         mode_ff <= mode_type'(req_tdata[REQ_MODE_LSB +: MODE_W]);
         key_ff  <= req_tdata[REQ_KEY_LSB +: KEY_W];
         prio_ff <= req_tdata[REQ_PRIO_LSB +: PRIO_W];
      end
      if (state_ff == S_APPLY) begin
         status_ff <= status_in;
         served_ff <= served_in;
      end
      if (state_ff == S_RESULT && rsp_free) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // ---- cell ring: cell i takes from cell i+1, the last from cell 0
   assign new_entry.key  = key_ff;
   assign new_entry.prio = prio_ff;

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      assign cell_ctrl[i].take_new = app_en && (state_ff == S_APPLY) &&
                                     (wr_idx == IDX_W'(i));
      assign cell_ctrl[i].take_nbr = rotate ||
                                     (cmp_en && (state_ff == S_APPLY) &&
                                      (IDX_W'(i) >= rm_idx));

      upq_cell u_cell (
         .clock     (clock),
         .ctrl      (cell_ctrl[i]),
         .nbr       (cell_q[(i + 1) % DEPTH]),
         .new_entry (new_entry),
         .q         (cell_q[i])
      );
   end

   upq_scan #(
      .IDX_W (IDX_W)
   ) u_scan (
      .clock     (clock),
      .reset     (reset),
      .clear     (scan_clear),
      .sample    (scan_sample),
      .head      (cell_q[0]),
      .pos       (pos_ff),
      .match_key (key_ff),
      .any_found (any_found),
      .any_entry (any_entry),
      .any_idx   (any_idx),
      .key_found (key_found),
      .key_prio  (key_prio),
      .key_idx   (key_idx)
   );

endmodule

// ----- hdl/upq_checker.sv -----
// ----------------------------------------------------------------------------
// upq_checker: port-level assertions for the unsorted priority queue
// Watches the request and response streams; bound to the top level.
// ----------------------------------------------------------------------------
module upq_checker import upq_pkg::*; (
   input logic             clock,
   input logic             reset,
   input logic             req_tvalid,
   input logic             req_tready,
   input logic             rsp_tvalid,
   input logic             rsp_tready,
   input logic [RSP_W-1:0] rsp_tdata
);

   logic [STATUS_W-1:0] status;
   logic [KEY_W-1:0]    served_key;
   logic                front_valid;
   logic [KEY_W-1:0]    front_key;
   logic [PRIO_W-1:0]   front_prio;

   assign status      = rsp_tdata[RSP_STATUS_LSB +: STATUS_W];
   assign served_key  = rsp_tdata[RSP_SERVED_LSB +: KEY_W];
   assign front_valid = rsp_tdata[RSP_FVALID_LSB];
   assign front_key   = rsp_tdata[RSP_FKEY_LSB +: KEY_W];
   assign front_prio  = rsp_tdata[RSP_FPRIO_LSB +: PRIO_W];

   // a stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("response changed while stalled");

   // one request at a time: busy right after a request transfer
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request taken while busy");

   a_served_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (served_key != '0) |-> (status == ST_OK))
      else $error("served key without successful serve");

   a_empty_serve: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (status == ST_EMPTY) |-> (served_key == '0) && !front_valid)
      else $error("empty serve reported a front or key");

   a_no_front: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !front_valid |-> (front_key == '0) && (front_prio == '0))
      else $error("front fields set on empty queue");

endmodule

bind unsorted_priority_queue upq_checker u_upq_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

// ----- test/unsorted_priority_queue_test.sv -----
// ----------------------------------------------------------------------------
// unsorted_priority_queue_test: self-checking bench for the priority queue
// Sends insert, serve, upgrade and clear requests with random gaps and random
// response stalls, predicts each response from a queue model kept in the
// bench, and compares every response field with the prediction in order.
// ----------------------------------------------------------------------------
module unsorted_priority_queue_test;
   import upq_pkg::*;

   localparam int QUEUE_DEPTH  = 64;
   localparam int DRAIN_CYCLES = 2 * QUEUE_DEPTH + 8;

   typedef struct {
      status_type        status;
      logic [KEY_W-1:0]  served_key;
      logic              front_valid;
      logic [KEY_W-1:0]  front_key;
      logic [PRIO_W-1:0] front_prio;
      logic [OCC_W-1:0]  occupancy;
   } queue_reply_type;

   logic             clock      = 1'b0;
   logic             reset      = 1'b1;
   logic             req_tvalid = 1'b0;
   logic             req_tready;
   logic [REQ_W-1:0] req_tdata  = '0;  // mode, key, priority_req
   logic             rsp_tvalid;
   logic             rsp_tready = 1'b0;
   logic [RSP_W-1:0] rsp_tdata;        // status, served_key, front_valid,
                                       // front_key, front_priority, occupancy

   // model of the queue contents, in arrival order
   logic [KEY_W-1:0]  held_key[$];
   logic [PRIO_W-1:0] held_prio[$];
   queue_reply_type   pending_replies[$];

   logic [KEY_W-1:0]  key_pool[8];
   int n_sent     = 0;
   int n_replied  = 0;
   int n_errors   = 0;
   int stall_left = 0;
   bit no_gaps    = 1'b0;

   always #5 clock = ~clock;

   unsorted_priority_queue #(
      .DEPTH(QUEUE_DEPTH)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata)
   );

   // lowest priority wins, earliest entry on ties
   function automatic int most_urgent_slot();
      int best = 0;
      for (int i = 1; i < held_prio.size(); i++) begin
         if (held_prio[i] < held_prio[best]) best = i;
      end
      return best;
   endfunction

   function automatic queue_reply_type apply_request(mode_type mode,
                                                     logic [KEY_W-1:0] key,
                                                     logic [PRIO_W-1:0] prio);
      queue_reply_type r;
      int hit;
      int slot;
      r.status     = ST_OK;
      r.served_key = '0;
      case (mode)
         MODE_INSERT: begin
            if (held_key.size() >= QUEUE_DEPTH) begin
               r.status = ST_FULL;
            end else begin
               held_key.push_back(key);
               held_prio.push_back(prio);
            end
         end
         MODE_SERVE: begin
            if (held_key.size() == 0) begin
               r.status = ST_EMPTY;
            end else begin
               slot = most_urgent_slot();
               r.served_key = held_key[slot];
               held_key.delete(slot);
               held_prio.delete(slot);
            end
         end
         MODE_UPGRADE: begin
            hit = -1;
            for (int i = 0; i < held_key.size(); i++) begin
               if (held_key[i] == key && (hit < 0 || held_prio[i] < held_prio[hit])) hit = i;
            end
            if (hit < 0) begin
               r.status = ST_ABSENT;
            end else if (held_prio[hit] <= prio) begin
               r.status = ST_NOT_LOWER;
            end else begin
               // decrease-key moves the entry to the tail
               held_key.delete(hit);
               held_prio.delete(hit);
               held_key.push_back(key);
               held_prio.push_back(prio);
            end
         end
         default: begin
            held_key.delete();
            held_prio.delete();
         end
      endcase
      r.occupancy = OCC_W'(held_key.size());
      if (held_key.size() > 0) begin
         slot = most_urgent_slot();
         r.front_valid = 1'b1;
         r.front_key   = held_key[slot];
         r.front_prio  = held_prio[slot];
      end else begin
         r.front_valid = 1'b0;
         r.front_key   = '0;
         r.front_prio  = '0;
      end
      return r;
   endfunction

   task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
      $display("%0t: %s: got %0h, want %0h", $time, what, got, want);
      n_errors++;
   endtask

   task automatic check_field(string what, logic [63:0] got, logic [63:0] want);
      if (got !== want) report_mismatch(what, got, want);
   endtask

   // response checker and request predictor share one process, so the order
   // of the expectation queue never depends on scheduling
   always @(posedge clock) begin : watch
      queue_reply_type want;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            if (pending_replies.size() == 0) begin
               report_mismatch("response with none expected", rsp_tdata, '0);
            end else begin
               want = pending_replies.pop_front();
               check_field("status", 64'(rsp_tdata[RSP_STATUS_LSB +: STATUS_W]),
                           64'(want.status));
               check_field("served_key", 64'(rsp_tdata[RSP_SERVED_LSB +: KEY_W]),
                           64'(want.served_key));
               check_field("front_valid", 64'(rsp_tdata[RSP_FVALID_LSB]),
                           64'(want.front_valid));
               check_field("front_key", 64'(rsp_tdata[RSP_FKEY_LSB +: KEY_W]),
                           64'(want.front_key));
               check_field("front_priority", 64'(rsp_tdata[RSP_FPRIO_LSB +: PRIO_W]),
                           64'(want.front_prio));
               check_field("occupancy", 64'(rsp_tdata[RSP_OCC_LSB +: OCC_W]),
                           64'(want.occupancy));
               n_replied++;
            end
         end
         if (req_tvalid && req_tready) begin
            pending_replies.push_back(apply_request(
               mode_type'(req_tdata[REQ_MODE_LSB +: MODE_W]),
               req_tdata[REQ_KEY_LSB +: KEY_W],
               req_tdata[REQ_PRIO_LSB +: PRIO_W]));
         end
      end
   end

   // response back-pressure: mostly ready, short stalls, now and then a long one
   always @(posedge clock) begin : sink
      int r;
      if (stall_left > 0) begin
         stall_left--;
         rsp_tready <= 1'b0;
      end else if (no_gaps) begin
         rsp_tready <= 1'b1;
      end else begin
         r = $urandom_range(0, 999);
         if (r < 880) begin
            rsp_tready <= 1'b1;
         end else begin
            rsp_tready <= 1'b0;
            stall_left = (r < 990) ? $urandom_range(0, 3) : $urandom_range(10, 40);
         end
      end
   end

   task automatic send_item(mode_type mode, logic [KEY_W-1:0] key, logic [PRIO_W-1:0] prio);
      int gap;
      int r;
      logic [REQ_W-1:0] word;
      word = '0;
      word[REQ_MODE_LSB +: MODE_W] = mode;
      word[REQ_KEY_LSB +: KEY_W]   = key;
      word[REQ_PRIO_LSB +: PRIO_W] = prio;
      r = $urandom_range(0, 99);
      if (no_gaps || r < 60) gap = 0;
      else if (r < 94) gap = $urandom_range(1, 3);
      else gap = $urandom_range(10, 30);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= word;
      do @(posedge clock); while (!req_tready);
      n_sent++;
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (n_replied < n_sent);
   endtask

   task automatic send_random_item(int w_insert, int w_serve, int w_upgrade);
      int r;
      int slot;
      mode_type mode;
      logic [KEY_W-1:0] key;
      logic [PRIO_W-1:0] prio;
      r = $urandom_range(0, 99);
      if (r < w_insert) mode = MODE_INSERT;
      else if (r < w_insert + w_serve) mode = MODE_SERVE;
      else if (r < w_insert + w_serve + w_upgrade) mode = MODE_UPGRADE;
      else mode = MODE_CLEAR;
      // small key pool so duplicates and upgrade hits are common
      key  = ($urandom_range(0, 9) < 8) ? key_pool[$urandom_range(0, 7)] : KEY_W'($urandom);
      prio = $urandom_range(0, 1) ? PRIO_W'($urandom) : PRIO_W'($urandom_range(0, 15));
      if (mode == MODE_UPGRADE && held_key.size() > 0 && $urandom_range(0, 3) != 0) begin
         slot = $urandom_range(0, held_key.size() - 1);
         key  = held_key[slot];
         if (held_prio[slot] > 0 && $urandom_range(0, 1)) begin
            prio = PRIO_W'($urandom_range(0, held_prio[slot] - 1));
         end
      end
      send_item(mode, key, prio);
   endtask

   task automatic test_empty_queue();
      send_item(MODE_SERVE, 16'h0000, 16'h0000);
      send_item(MODE_UPGRADE, 16'h1234, 16'h0000);
      send_item(MODE_CLEAR, 16'hFFFF, 16'hFFFF);
   endtask

   task automatic test_ordering();
      send_item(MODE_INSERT, 16'h0000, 16'hFFFF);
      send_item(MODE_INSERT, 16'hFFFF, 16'h0000);
      send_item(MODE_INSERT, 16'h00A5, 16'h0000);  // tie: earlier entry is served first
      send_item(MODE_SERVE, 16'h0000, 16'h0000);
      send_item(MODE_SERVE, 16'h0000, 16'h0000);
      send_item(MODE_SERVE, 16'h0000, 16'h0000);
      send_item(MODE_SERVE, 16'h0000, 16'h0000);
   endtask

   task automatic test_upgrade();
      send_item(MODE_INSERT, 16'd7, 16'd100);
      send_item(MODE_INSERT, 16'd7, 16'd50);
      send_item(MODE_INSERT, 16'd9, 16'd50);
      send_item(MODE_UPGRADE, 16'd8, 16'd0);    // key not held
      send_item(MODE_UPGRADE, 16'd7, 16'd50);   // equal is not lower
      send_item(MODE_UPGRADE, 16'd7, 16'd60);
      send_item(MODE_UPGRADE, 16'd7, 16'd49);   // moves to tail, becomes front
      send_item(MODE_UPGRADE, 16'd9, 16'd0);
      send_item(MODE_CLEAR, 16'd0, 16'd0);
   endtask

   task automatic test_full_queue();
      while (held_key.size() < QUEUE_DEPTH) begin
         send_item(MODE_INSERT, KEY_W'($urandom), PRIO_W'($urandom));
      end
      repeat (2) send_item(MODE_INSERT, KEY_W'($urandom), PRIO_W'($urandom));
      wait_drained();
      send_item(MODE_UPGRADE, held_key[$urandom_range(0, QUEUE_DEPTH - 1)], 16'h0000);
      send_item(MODE_SERVE, KEY_W'($urandom), PRIO_W'($urandom));
      send_item(MODE_INSERT, 16'hFFFF, 16'hFFFF);
      send_item(MODE_INSERT, 16'h0000, 16'h0000);
      send_item(MODE_CLEAR, KEY_W'($urandom), PRIO_W'($urandom));
   endtask

   task automatic test_random_traffic();
      int sent = 0;
      int round = 0;
      int w_insert;
      int w_serve;
      int w_upgrade;
      while (sent < 1650) begin
         foreach (key_pool[i]) key_pool[i] = KEY_W'($urandom);
         case (round % 4)
            0: begin
               w_insert = 45; w_serve = 25; w_upgrade = 29;
            end
            1: begin  // fills the queue
               w_insert = 75; w_serve = 8; w_upgrade = 16;
            end
            2: begin  // drains it and hits empty serves
               w_insert = 20; w_serve = 55; w_upgrade = 24;
            end
            default: begin
               w_insert = 35; w_serve = 15; w_upgrade = 49;
            end
         endcase
         no_gaps = (round % 5 == 3);
         if (round % 3 == 2) wait_drained();
         repeat (120) begin
            send_random_item(w_insert, w_serve, w_upgrade);
            sent++;
         end
         round++;
      end
      no_gaps = 1'b0;
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      test_empty_queue();
      test_ordering();
      test_upgrade();
      test_full_queue();
      test_random_traffic();
      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (n_errors == 0) $display("No mismatches found");
      else $display("Mismatches found");
      $finish;
   end

   initial begin
      #15_000_000;
      $display("Mismatches found");
      $finish;
   end

endmodule

// ----- sim.f -----
hdl/upq_pkg.sv
hdl/upq_cell.sv
hdl/upq_scan.sv
hdl/unsorted_priority_queue.sv
hdl/upq_checker.sv
test/unsorted_priority_queue_test.sv
